>>> hw/rtl/rsi_pkg.sv
// Shared types and constants for the ray-sphere intersection pipeline.
package rsi_pkg;

  localparam int CW = 32;              // coordinate width
  localparam int WW = 33;              // o - c difference width
  localparam int AW = 66;              // a = d.d (unsigned)
  localparam int HW = 68;              // h = d.w (signed)
  localparam int QW = 69;              // cq (signed)
  localparam int DW = 138;             // discriminant (signed)
  localparam int SW = 69;              // floor(sqrt(D)) (unsigned)
  localparam int NW = 70;              // root numerator (unsigned)
  localparam int PW = 101;             // |d| * N (unsigned)
  localparam int OW = 102;             // signed offset
  localparam logic signed [CW-1:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [CW-1:0] SAT_MIN = 32'sh80000000;

  typedef logic signed [CW-1:0] coord_t;

  function automatic coord_t sat32(input logic signed [OW:0] v);
    if (v > $signed({{(OW-CW+1){1'b0}}, SAT_MAX})) return SAT_MAX;
    if (v < $signed({{(OW-CW+1){1'b1}}, SAT_MIN})) return SAT_MIN;
    return v[CW-1:0];
  endfunction

endpackage

>>> hw/rtl/ray_sphere_intersection.sv
// Top level: pipelined ray-sphere intersection test.
// Usage: one ray/sphere pair enters on the in_ channel as one beat; one
// result beat (hit flag and saturated hit point) leaves on the out_ channel.
// A beat is taken at a rising edge where valid is high and stall is low.
// From input beat to output beat the pipeline has six stages up to the
// discriminant, one stage per root bit, one for the root numerator, two for
// the offset products, one stage per quotient bit and the output register.
// A new beat is taken every cycle while in_stall is low.
// The whole pipeline advances together: while out_valid and out_stall are
// both high, every stage holds and in_stall is high, so nothing is lost or
// repeated. Empty stages are not squeezed out, so a stalled result beat
// blocks the input even when the pipeline holds gaps.
// A zero direction, a negative discriminant or two negative roots give
// hit low with a zero point. Reset (rst_n low, synchronous) clears all
// valid bits; payload registers are not reset.
// FRAC_BITS only names the fixed-point format: the scales cancel, so the
// integer datapath is the same for every value.
module ray_sphere_intersection import rsi_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_center_z,
  input  logic [30:0]        in_sphere_radius,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic signed [31:0] out_hit_x,
  output logic signed [31:0] out_hit_y,
  output logic signed [31:0] out_hit_z
);
  localparam int NSQ  = SW;
  localparam int NDV  = PW;
  localparam int LAT  = 6 + NSQ + 1 + 2 + NDV + 1;

  logic en;
  logic [LAT-1:0] vld_r;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
  end

  // Stage 1: register inputs, form w = o - c.
  coord_t o1_r [3], d1_r [3];
  logic signed [WW-1:0] w1_r [3];
  logic [30:0] r1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      o1_r[0] <= in_origin_x; o1_r[1] <= in_origin_y; o1_r[2] <= in_origin_z;
      d1_r[0] <= in_dir_x; d1_r[1] <= in_dir_y; d1_r[2] <= in_dir_z;
      w1_r[0] <= WW'(in_origin_x) - WW'(in_center_x);
      w1_r[1] <= WW'(in_origin_y) - WW'(in_center_y);
      w1_r[2] <= WW'(in_origin_z) - WW'(in_center_z);
      r1_r    <= in_sphere_radius;
    end
  end

  // Stage 2: products.
  coord_t o2_r [3], d2_r [3];
  logic [2*CW-1:0] dd2_r [3];
  logic signed [CW+WW-1:0] dw2_r [3];
  logic [2*WW-1:0] ww2_r [3];
  logic [61:0] rr2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        o2_r[k]  <= o1_r[k];
        d2_r[k]  <= d1_r[k];
        dd2_r[k] <= (2*CW)'($unsigned(64'(d1_r[k]) * 64'(d1_r[k])));
        dw2_r[k] <= (CW+WW)'(d1_r[k]) * (CW+WW)'(w1_r[k]);
        ww2_r[k] <= (2*WW)'($unsigned((2*WW)'(w1_r[k]) * (2*WW)'(w1_r[k])));
      end
      rr2_r <= 62'(r1_r) * 62'(r1_r);
    end
  end

  // Stage 3: sums a, h, cq.
  coord_t o3_r [3], d3_r [3];
  logic [AW-1:0] a3_r;
  logic signed [HW-1:0] h3_r;
  logic signed [QW-1:0] c3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin o3_r[k] <= o2_r[k]; d3_r[k] <= d2_r[k]; end
      a3_r <= AW'(dd2_r[0]) + AW'(dd2_r[1]) + AW'(dd2_r[2]);
      h3_r <= HW'(dw2_r[0]) + HW'(dw2_r[1]) + HW'(dw2_r[2]);
      c3_r <= $signed(QW'(ww2_r[0]) + QW'(ww2_r[1]) + QW'(ww2_r[2])) -
              $signed(QW'(rr2_r));
    end
  end

  // Stage 4: |h|, |cq| and a split into 33-bit halves; partial products.
  logic signed [HW-1:0] hneg;
  logic signed [QW-1:0] cneg;
  logic [65:0] habs, cabs;
  assign hneg = -h3_r;
  assign cneg = -c3_r;
  assign habs = h3_r[HW-1] ? hneg[65:0] : h3_r[65:0];
  assign cabs = c3_r[QW-1] ? cneg[65:0] : c3_r[65:0];
  coord_t op_r [3], dp_r [3];
  logic [AW-1:0] ap_r;
  logic signed [HW-1:0] hs_r;
  logic hpos_p_r, cneg_p_r, cpos_p_r, az_p_r;
  logic [65:0] hhh_r, hhl_r, hll_r, ahh_r, ahl_r, alh_r, all_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin op_r[k] <= o3_r[k]; dp_r[k] <= d3_r[k]; end
      ap_r     <= a3_r;
      hs_r     <= h3_r;
      hpos_p_r <= (h3_r > 0);
      cneg_p_r <= c3_r[QW-1];
      cpos_p_r <= (c3_r > 0);
      az_p_r   <= (a3_r == '0);
      hhh_r    <= 66'(habs[65:33]) * 66'(habs[65:33]);
      hhl_r    <= 66'(habs[65:33]) * 66'(habs[32:0]);
      hll_r    <= 66'(habs[32:0]) * 66'(habs[32:0]);
      ahh_r    <= 66'(a3_r[65:33]) * 66'(cabs[65:33]);
      ahl_r    <= 66'(a3_r[65:33]) * 66'(cabs[32:0]);
      alh_r    <= 66'(a3_r[32:0]) * 66'(cabs[65:33]);
      all_r    <= 66'(a3_r[32:0]) * 66'(cabs[32:0]);
    end
  end

  // Stage 5: h^2 and a*|cq| assembled from the partial products.
  coord_t om_r [3], dm_r [3];
  logic [AW-1:0] am_r;
  logic signed [HW-1:0] hm_r;
  logic hpos_m_r, cneg_m_r, cpos_m_r, az_m_r;
  logic [DW-1:0] hsq_r, acq_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin om_r[k] <= op_r[k]; dm_r[k] <= dp_r[k]; end
      am_r     <= ap_r;
      hm_r     <= hs_r;
      hpos_m_r <= hpos_p_r;
      cneg_m_r <= cneg_p_r;
      cpos_m_r <= cpos_p_r;
      az_m_r   <= az_p_r;
      hsq_r    <= (DW'(hhh_r) << 66) + (DW'(hhl_r) << 34) + DW'(hll_r);
      acq_r    <= (DW'(ahh_r) << 66) + (DW'(ahl_r) << 33) + (DW'(alh_r) << 33) +
                  DW'(all_r);
    end
  end

  // Stage 6: discriminant h^2 - a*cq.
  coord_t o4_r [3], d4_r [3];
  logic [AW-1:0] a4_r;
  logic signed [HW-1:0] h4_r;
  logic hp4_r, cn4_r, ok4_r;
  logic [DW-1:0] ds4_r;
  logic signed [DW-1:0] disc;
  assign disc = cneg_m_r ? $signed(hsq_r + acq_r) : $signed(hsq_r - acq_r);
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin o4_r[k] <= om_r[k]; d4_r[k] <= dm_r[k]; end
      a4_r  <= am_r;
      h4_r  <= hm_r;
      hp4_r <= hpos_m_r;
      cn4_r <= cneg_m_r;
      // No hit on zero direction, negative discriminant or both roots behind.
      ok4_r <= !az_m_r && !disc[DW-1] && !(hpos_m_r && cpos_m_r);
      ds4_r <= disc[DW-1] ? '0 : disc;
    end
  end

  // Square root chain.
  logic [DW-1:0] sq_rem [NSQ+1];
  logic [SW-1:0] sq_root [NSQ+1];
  assign sq_rem[0]  = ds4_r;
  assign sq_root[0] = '0;
  coord_t oq_r [NSQ][3], dq_r [NSQ][3];
  logic [AW-1:0] aq_r [NSQ];
  logic signed [HW-1:0] hq_r [NSQ];
  logic nq_r [NSQ], okq_r [NSQ];
  for (genvar g = 0; g < NSQ; g++) begin : g_sq
    rsi_sqrt_stage #(.BIT(NSQ - 1 - g)) u_st (
      .clk(clk), .en(en), .rem_i(sq_rem[g]), .root_i(sq_root[g]),
      .rem_o(sq_rem[g+1]), .root_o(sq_root[g+1])
    );
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          for (int k = 0; k < 3; k++) begin oq_r[g][k] <= o4_r[k]; dq_r[g][k] <= d4_r[k]; end
          aq_r[g] <= a4_r; hq_r[g] <= h4_r;
          nq_r[g] <= !hp4_r && !cn4_r; okq_r[g] <= ok4_r;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          for (int k = 0; k < 3; k++) begin
            oq_r[g][k] <= oq_r[g-1][k]; dq_r[g][k] <= dq_r[g-1][k];
          end
          aq_r[g] <= aq_r[g-1]; hq_r[g] <= hq_r[g-1];
          nq_r[g] <= nq_r[g-1]; okq_r[g] <= okq_r[g-1];
        end
      end
    end
  end

  // Numerator stage.
  coord_t on_r [3], dn_r [3];
  logic [AW-1:0] an_r;
  logic [NW-1:0] num_r;
  logic okn_r;
  logic signed [NW-1:0] nh, nnum;
  assign nh   = -NW'(hq_r[NSQ-1]);
  assign nnum = nq_r[NSQ-1] ? nh - $signed(NW'(sq_root[NSQ])) : nh + $signed(NW'(sq_root[NSQ]));
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin on_r[k] <= oq_r[NSQ-1][k]; dn_r[k] <= dq_r[NSQ-1][k]; end
      an_r  <= aq_r[NSQ-1];
      num_r <= okq_r[NSQ-1] ? nnum : '0;
      okn_r <= okq_r[NSQ-1];
    end
  end

  // Offset products |d|*N from the two 35-bit halves of N, summed a stage later.
  logic [31:0] mag [3];
  for (genvar k = 0; k < 3; k++) begin : g_mag
    assign mag[k] = dn_r[k][31] ? 32'(-dn_r[k]) : 32'(dn_r[k]);
  end
  coord_t ox_r [3];
  logic sx_r [3];
  logic [AW-1:0] ax_r;
  logic okx_r;
  logic [66:0] plo_r [3], phi_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ox_r[k]  <= on_r[k];
        sx_r[k]  <= dn_r[k][31];
        plo_r[k] <= 67'(mag[k]) * 67'(num_r[34:0]);
        phi_r[k] <= 67'(mag[k]) * 67'(num_r[69:35]);
      end
      ax_r  <= an_r;
      okx_r <= okn_r;
    end
  end

  coord_t oy_r [3];
  logic sy_r [3];
  logic [AW-1:0] ay_r;
  logic oky_r;
  logic [PW-1:0] prod_r [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        oy_r[k]   <= ox_r[k];
        sy_r[k]   <= sx_r[k];
        prod_r[k] <= (PW'(phi_r[k]) << 35) + PW'(plo_r[k]);
      end
      ay_r  <= ax_r;
      oky_r <= okx_r;
    end
  end

  // Division lanes |d|*N / a.
  logic [2:0][PW-1:0] dv_rem [NDV+1];
  logic [2:0][PW-1:0] dv_q [NDV+1];
  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign dv_rem[0][k] = prod_r[k];
    assign dv_q[0][k]   = '0;
  end
  coord_t ov_r [NDV][3];
  logic sv_r [NDV][3];
  logic [AW-1:0] av_r [NDV];
  logic okv_r [NDV];
  for (genvar g = 0; g < NDV; g++) begin : g_dv
    if (g == 0) begin : g_first
      rsi_div_stage #(.BIT(NDV - 1)) u_st (
        .clk(clk), .en(en), .dv(ay_r),
        .rem_i(dv_rem[g]), .q_i(dv_q[g]), .rem_o(dv_rem[g+1]), .q_o(dv_q[g+1])
      );
      always_ff @(posedge clk) begin
        if (en) begin
          for (int k = 0; k < 3; k++) begin
            ov_r[g][k] <= oy_r[k];
            sv_r[g][k] <= sy_r[k];
          end
          av_r[g]  <= ay_r;
          okv_r[g] <= oky_r;
        end
      end
    end else begin : g_next
      rsi_div_stage #(.BIT(NDV - 1 - g)) u_st (
        .clk(clk), .en(en), .dv(av_r[g-1]),
        .rem_i(dv_rem[g]), .q_i(dv_q[g]), .rem_o(dv_rem[g+1]), .q_o(dv_q[g+1])
      );
      always_ff @(posedge clk) begin
        if (en) begin
          for (int k = 0; k < 3; k++) begin
            ov_r[g][k] <= ov_r[g-1][k];
            sv_r[g][k] <= sv_r[g-1][k];
          end
          av_r[g]  <= av_r[g-1];
          okv_r[g] <= okv_r[g-1];
        end
      end
    end
  end

  // Output register: apply sign, add origin, saturate.
  coord_t hx_r [3];
  logic hit_r;
  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= okv_r[NDV-1];
      for (int k = 0; k < 3; k++) begin
        logic signed [OW:0] off, sum;
        off = sv_r[NDV-1][k] ? -$signed((OW+1)'(dv_q[NDV][k])) : $signed((OW+1)'(dv_q[NDV][k]));
        sum = off + (OW+1)'(ov_r[NDV-1][k]);
        hx_r[k] <= okv_r[NDV-1] ? sat32(sum) : '0;
      end
    end
  end

  assign out_valid = vld_r[LAT-1];
  assign out_hit   = hit_r;
  assign out_hit_x = hx_r[0];
  assign out_hit_y = hx_r[1];
  assign out_hit_z = hx_r[2];
endmodule

>>> hw/rtl/rsi_sqrt_stage.sv
// One registered step of the restoring integer square root.
module rsi_sqrt_stage import rsi_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic            clk,
  input  logic            en,
  input  logic [DW-1:0]   rem_i,
  input  logic [SW-1:0]   root_i,
  output logic [DW-1:0]   rem_o,
  output logic [SW-1:0]   root_o
);
  logic [DW-1:0] trial;
  logic [DW-1:0] rem_r;
  logic [SW-1:0] root_r;

  // Trial subtrahend is (2*root + 2^BIT) * 2^BIT with root holding bits above BIT.
  assign trial = (DW'(root_i) << (BIT + 1)) + (DW'(1) << (2 * BIT));

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_i >= trial) begin
        rem_r  <= rem_i - trial;
        root_r <= root_i | (SW'(1) << BIT);
      end else begin
        rem_r  <= rem_i;
        root_r <= root_i;
      end
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
endmodule

>>> hw/rtl/rsi_div_stage.sv
// One registered step of the restoring divider, three lanes sharing one divisor.
module rsi_div_stage import rsi_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [AW-1:0]        dv,
  input  logic [2:0][PW-1:0]   rem_i,
  input  logic [2:0][PW-1:0]   q_i,
  output logic [2:0][PW-1:0]   rem_o,
  output logic [2:0][PW-1:0]   q_o
);
  logic [2:0][PW-1:0] rem_r, q_r;
  logic [PW+AW-1:0]   sh;

  assign sh = (PW+AW)'(dv) << BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        if ((PW+AW)'(rem_i[k]) >= sh) begin
          rem_r[k] <= rem_i[k] - sh[PW-1:0];
          q_r[k]   <= q_i[k] | (PW'(1) << BIT);
        end else begin
          rem_r[k] <= rem_i[k];
          q_r[k]   <= q_i[k];
        end
      end
    end
  end

  assign rem_o = rem_r;
  assign q_o   = q_r;
endmodule

>>> sim/tb.sv
// Self-checking bench for the ray-sphere intersection pipeline, with an exact wide-integer predictor.
module tb;

  typedef struct packed {
    logic signed [31:0] ox, oy, oz, dx, dy, dz, cx, cy, cz;
    logic [30:0] rad;
  } ray_t;

  typedef struct packed {
    logic hit;
    logic signed [31:0] hx, hy, hz;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [31:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [31:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic [30:0] in_sphere_radius = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic signed [31:0] out_hit_x, out_hit_y, out_hit_z;

  ray_sphere_intersection dut (.*);

  ray_t   pending_rays[$];
  point_t expected_points[$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_off = 1'b0;
  bit     stim_done = 1'b0;
  int     quiet_cycles = 0;

  initial forever #1 clk = ~clk;

  // Integer square root by one bit per step from the top.
  function automatic logic [159:0] isqrt(input logic [159:0] x);
    logic [159:0] r, cand;
    r = '0;
    for (int i = 79; i >= 0; i--) begin
      cand = r | (160'd1 << i);
      if (cand * cand <= x) r = cand;
    end
    return r;
  endfunction

  function automatic point_t trace_ray(input ray_t r);
    point_t p;
    logic signed [159:0] o[3], d[3], w[3], a, h, cq, disc, num, off, v, mag;
    logic [159:0] s;
    o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
    d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
    w[0] = o[0] - 160'(signed'(r.cx));
    w[1] = o[1] - 160'(signed'(r.cy));
    w[2] = o[2] - 160'(signed'(r.cz));
    p = '0;
    a = d[0]*d[0] + d[1]*d[1] + d[2]*d[2];
    h = d[0]*w[0] + d[1]*w[1] + d[2]*w[2];
    cq = w[0]*w[0] + w[1]*w[1] + w[2]*w[2] - $signed({129'd0, r.rad}) * $signed({129'd0, r.rad});
    if (a == 0) return p;
    disc = h*h - a*cq;
    if (disc < 0) return p;
    if (h > 0 && cq > 0) return p;
    s = isqrt(disc);
    // Near root when it is non-negative, otherwise the far one.
    if (h <= 0 && cq >= 0) num = -h - $signed(s);
    else num = -h + $signed(s);
    p.hit = 1'b1;
    for (int k = 0; k < 3; k++) begin
      mag = d[k] < 0 ? -d[k] : d[k];
      off = $signed($unsigned(mag * num) / $unsigned(a));
      if (d[k] < 0) off = -off;
      v = o[k] + off;
      if (v > 160'sd2147483647) v = 160'sd2147483647;
      if (v < -160'sd2147483648) v = -160'sd2147483648;
      if (k == 0) p.hx = v[31:0];
      else if (k == 1) p.hy = v[31:0];
      else p.hz = v[31:0];
    end
    return p;
  endfunction

  function automatic logic [31:0] rand_coord(input int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      default: return 32'($signed($urandom_range(0, 200000)) - 100000) <<< 8;
    endcase
  endfunction

  // Random ray aimed roughly at a sphere so that most items hit.
  function automatic ray_t rand_ray();
    ray_t r;
    int mode;
    mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
    r.ox = rand_coord(mode); r.oy = rand_coord(mode); r.oz = rand_coord(mode);
    r.cx = rand_coord(mode); r.cy = rand_coord(mode); r.cz = rand_coord(mode);
    if (mode != 0 && $urandom_range(0, 3) != 0) begin
      r.dx = (r.cx - r.ox) >>> $urandom_range(0, 4);
      r.dy = (r.cy - r.oy) >>> $urandom_range(0, 4);
      r.dz = (r.cz - r.oz) >>> $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) r.dx = -r.dx;
    end else begin
      r.dx = rand_coord(mode); r.dy = rand_coord(mode); r.dz = rand_coord(mode);
    end
    r.rad = mode == 0 ? 31'($urandom) : 31'($urandom_range(0, 600)) << 16;
    if ($urandom_range(0, 49) == 0) {r.dx, r.dy, r.dz} = '0;
    return r;
  endfunction

  function automatic ray_t mk(input int ox, oy, oz, dx, dy, dz, cx, cy, cz, input int rad);
    ray_t r;
    r.ox = ox; r.oy = oy; r.oz = oz; r.dx = dx; r.dy = dy; r.dz = dz;
    r.cx = cx; r.cy = cy; r.cz = cz; r.rad = 31'(rad);
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_rays.size() != 0 || expected_points.size() != 0) @(posedge clk);
  endtask

  initial begin
    int one;
    one = 32'h10000;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: front hit, origin inside, miss, behind, zero direction,
    // grazing, far root at exactly zero, saturation and field extremes.
    pending_rays.push_back(mk(0, 0, -10*one, 0, 0, one, 0, 0, 0, one));
    pending_rays.push_back(mk(0, 0, 0, one, 0, 0, 0, 0, 0, 2*one));
    pending_rays.push_back(mk(0, 5*one, -10*one, 0, 0, one, 0, 0, 0, one));
    pending_rays.push_back(mk(0, 0, 10*one, 0, 0, one, 0, 0, 0, one));
    pending_rays.push_back(mk(0, 0, -10*one, 0, 0, 0, 0, 0, 0, one));
    pending_rays.push_back(mk(0, one, -10*one, 0, 0, one, 0, 0, 0, one));
    pending_rays.push_back(mk(one, 0, 0, one, 0, 0, 0, 0, 0, one));
    pending_rays.push_back(mk(-one, 0, 0, one, 0, 0, 0, 0, 0, one));
    pending_rays.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
      32'h80000000, 32'h7fffffff));
    pending_rays.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000,
      32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
      32'h7fffffff, 32'h7fffffff));
    pending_rays.push_back(mk(0, 0, 0, 1, 0, 0, 32'h7fff0000, 0, 0, 32'h7fffffff));
    pending_rays.push_back(mk(0, 0, 0, -1, -1, -1, 0, 0, 0, 32'h7fffffff));
    pending_rays.push_back(mk(-1, -1, -1, 1, 1, 1, 0, 0, 0, 0));
    pending_rays.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        3: begin send_idle_pct = 19; recv_stall_pct = 19; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 4) hold_off = 1'b1;
      for (int i = 0; i < 330; i++) pending_rays.push_back(rand_ray());
      wait_drained();
    end
    repeat (200) @(posedge clk);
    stim_done = 1'b1;
  end

  // Driver: the beat on offer is the head of the queue and stays put until taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        expected_points.push_back(trace_ray(pending_rays.pop_front()));
      end
      if (pending_rays.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        {in_origin_x, in_origin_y, in_origin_z, in_dir_x, in_dir_y, in_dir_z,
         in_center_x, in_center_y, in_center_z, in_sphere_radius} <= pending_rays[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off of its own.
  int hold_count = 0;
  always @(posedge clk) begin
    if (hold_off && hold_count < 600) begin
      hold_count <= hold_count + 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(0, 99) < recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        $display("%0t: result beat with none expected: hit %0b (%0d,%0d,%0d)",
          $time, out_hit, out_hit_x, out_hit_y, out_hit_z);
        errors++;
      end else begin
        point_t e;
        e = expected_points.pop_front();
        if (out_hit !== e.hit || out_hit_x !== e.hx || out_hit_y !== e.hy ||
            out_hit_z !== e.hz) begin
          $display("%0t: expected hit %0b (%0d,%0d,%0d), got hit %0b (%0d,%0d,%0d)",
            $time, e.hit, e.hx, e.hy, e.hz, out_hit, out_hit_x, out_hit_y, out_hit_z);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("ray_sphere_intersection: mismatch");
      $finish;
    end else if (stim_done) begin
      if (errors == 0 && expected_points.size() == 0)
        $display("ray_sphere_intersection: match");
      else
        $display("ray_sphere_intersection: mismatch");
      $finish;
    end
  end

endmodule
